/* sv/ows_pkg.sv */
// Shared types, codes and the CRC-8 helper for the 1-Wire ROM search engine.
package ows_pkg;

    localparam int unsigned ROM_BITS    = 64;
    localparam int unsigned FAMILY_BITS = 8;
    localparam logic [7:0]  CRC_POLY    = 8'h8C;

    typedef enum logic [1:0] {
        CMD_FIRST    = 2'd0,
        CMD_NEXT     = 2'd1,
        CMD_PRESENCE = 2'd2,
        CMD_BITS     = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_RESET    = 3'd0,
        ST_SEARCH   = 3'd1,
        ST_CONTINUE = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NONE     = 3'd4,
        ST_IGNORED  = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_PRESENCE = 2'd1,
        PH_SEARCH   = 2'd2
    } t_phase;

    typedef struct packed {
        t_cmd command;
        logic presence;
        logic id_bit;
        logic complement_bit;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic        write_valid;
        logic        direction;
        logic [63:0] rom_code;
        logic        last_device;
        logic [3:0]  family_discrepancy;
    } t_result;

    // Dallas CRC-8, reflected, one byte LSB first
    function automatic logic [7:0] ows_crc_byte(input logic [7:0] crc_in,
                                                input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] b;
        logic       mix;
        crc = crc_in;
        b   = data;
        for (int i = 0; i < 8; i++) begin
            mix = crc[0] ^ b[0];
            crc = crc >> 1;
            if (mix) begin
                crc = crc ^ CRC_POLY;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

/* sv/ows_core.sv */
// Search decision logic and the search state registers, one event per step.
module ows_core
    import ows_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_step,
    input  t_item   i_item,
    output t_result o_result
);

    localparam logic [6:0] ROM_LAST = 7'(ROM_BITS);
    localparam logic [6:0] FAM_LAST = 7'(FAMILY_BITS);

    logic [63:0] r_rom,      n_rom;
    logic [6:0]  r_last_disc, n_last_disc;
    logic [3:0]  r_fam_disc, n_fam_disc;
    logic        r_last_dev, n_last_dev;
    logic [6:0]  r_bit_pos,  n_bit_pos;
    logic [6:0]  r_zero_pos, n_zero_pos;
    logic [7:0]  r_crc,      n_crc;
    t_phase      r_phase,    n_phase;

    t_status     w_status;
    logic        w_wv;
    logic        w_dir;
    logic [5:0]  w_idx;
    logic [7:0]  w_byte;
    logic [7:0]  w_crc_new;
    logic        w_ok;
    logic        w_in_range;

    assign w_idx      = 6'(r_bit_pos - 7'd1);
    assign w_in_range = (r_bit_pos >= 7'd1) && (r_bit_pos <= ROM_LAST);

    // Decide the action and the next search state
    always_comb begin
        n_rom       = r_rom;
        n_last_disc = r_last_disc;
        n_fam_disc  = r_fam_disc;
        n_last_dev  = r_last_dev;
        n_bit_pos   = r_bit_pos;
        n_zero_pos  = r_zero_pos;
        n_crc       = r_crc;
        n_phase     = r_phase;
        w_status    = ST_IGNORED;
        w_wv        = 1'b0;
        w_dir       = 1'b0;
        w_byte      = 8'd0;
        w_crc_new   = r_crc;
        w_ok        = 1'b0;

        unique case (i_item.command) inside
            CMD_FIRST, CMD_NEXT: begin
                n_bit_pos  = 7'd1;
                n_zero_pos = 7'd0;
                n_crc      = 8'd0;
                if ((i_item.command == CMD_NEXT) && r_last_dev) begin
                    n_last_disc = 7'd0;
                    n_last_dev  = 1'b0;
                    n_fam_disc  = 4'd0;
                    n_phase     = PH_IDLE;
                    w_status    = ST_NONE;
                end else begin
                    if (i_item.command == CMD_FIRST) begin
                        n_last_disc = 7'd0;
                        n_last_dev  = 1'b0;
                        n_fam_disc  = 4'd0;
                    end
                    n_phase  = PH_PRESENCE;
                    w_status = ST_RESET;
                end
            end
            CMD_PRESENCE: begin
                if (r_phase == PH_PRESENCE) begin
                    if (i_item.presence) begin
                        n_phase  = PH_SEARCH;
                        w_status = ST_SEARCH;
                    end else begin
                        n_last_disc = 7'd0;
                        n_last_dev  = 1'b0;
                        n_fam_disc  = 4'd0;
                        n_phase     = PH_IDLE;
                        w_status    = ST_NONE;
                    end
                end
            end
            default: begin
                if (r_phase == PH_SEARCH) begin
                    if (!w_in_range || (i_item.id_bit && i_item.complement_bit)) begin
                        // no device answered, or the bit position is out of range: drop the search
                        n_last_disc = 7'd0;
                        n_last_dev  = 1'b0;
                        n_fam_disc  = 4'd0;
                        n_phase     = PH_IDLE;
                        w_status    = ST_NONE;
                    end else begin
                        if (i_item.id_bit != i_item.complement_bit) begin
                            w_dir = i_item.id_bit;
                        end else begin
                            // discrepancy: follow the earlier path or branch
                            if (r_bit_pos < r_last_disc) begin
                                w_dir = r_rom[w_idx];
                            end else begin
                                w_dir = (r_bit_pos == r_last_disc);
                            end
                            if (!w_dir) begin
                                n_zero_pos = r_bit_pos;
                                if (r_bit_pos <= FAM_LAST) begin
                                    n_fam_disc = r_bit_pos[3:0];
                                end
                            end
                        end
                        n_rom[w_idx] = w_dir;
                        w_wv         = 1'b1;
                        w_byte       = n_rom[{w_idx[5:3], 3'b000} +: 8];
                        if (r_bit_pos[2:0] == 3'd0) begin
                            w_crc_new = ows_crc_byte(r_crc, w_byte);
                            n_crc     = w_crc_new;
                        end
                        n_bit_pos = r_bit_pos + 7'd1;
                        if (r_bit_pos == ROM_LAST) begin
                            w_ok    = (w_crc_new == 8'd0) && (n_rom[7:0] != 8'd0);
                            n_phase = PH_IDLE;
                            if (w_ok) begin
                                n_last_disc = n_zero_pos;
                                if (n_zero_pos == 7'd0) begin
                                    n_last_dev = 1'b1;
                                end
                                w_status = ST_FOUND;
                            end else begin
                                n_last_disc = 7'd0;
                                n_last_dev  = 1'b0;
                                n_fam_disc  = 4'd0;
                                w_status    = ST_NONE;
                            end
                        end else begin
                            w_status = ST_CONTINUE;
                        end
                    end
                end
            end
        endcase
    end

    // Present the result of this step
    always_comb begin
        o_result.status             = w_status;
        o_result.write_valid        = w_wv;
        o_result.direction          = w_dir;
        o_result.rom_code           = n_rom;
        o_result.last_device        = n_last_dev;
        o_result.family_discrepancy = n_fam_disc;
    end

    // Advance the search state on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom       <= '0;
            r_last_disc <= '0;
            r_fam_disc  <= '0;
            r_last_dev  <= 1'b0;
            r_bit_pos   <= 7'd1;
            r_zero_pos  <= '0;
            r_crc       <= '0;
            r_phase     <= PH_IDLE;
        end else if (i_step) begin
            r_rom       <= n_rom;
            r_last_disc <= n_last_disc;
            r_fam_disc  <= n_fam_disc;
            r_last_dev  <= n_last_dev;
            r_bit_pos   <= n_bit_pos;
            r_zero_pos  <= n_zero_pos;
            r_crc       <= n_crc;
            r_phase     <= n_phase;
        end
    end

endmodule

/* sv/onewire_rom_search_engine.sv */
// 1-Wire ROM search engine: input register, decision core, result register.
// An accepted event is held in the input register, passes through the decision core
// into the result register and is offered from there; a stalled result stage delays it.
// Throughput: one event per cycle while the result stage is not stalled; the search state
// updates in a single step. Input stalls only while a held event cannot move into a
// stalled result stage. Reset (synchronous, active low) empties both stages and returns
// the search state to idle with bit position one and all other state zero.
module onewire_rom_search_engine
    import ows_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic        i_presence,
    input  logic        i_id_bit,
    input  logic        i_complement_bit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic        o_write_valid,
    output logic        o_direction,
    output logic [63:0] o_rom_code,
    output logic        o_last_device,
    output logic [3:0]  o_family_discrepancy
);

    logic    r_in_valid;
    t_item   r_item;
    logic    r_out_valid;
    t_result r_result;
    t_result w_result;
    logic    w_step;
    logic    w_accept;

    // Move the held beat into the result stage when that stage is free or its beat is taken
    assign w_step     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_step;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Hold the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item.command        <= t_cmd'(i_command);
            r_item.presence       <= i_presence;
            r_item.id_bit         <= i_id_bit;
            r_item.complement_bit <= i_complement_bit;
        end
    end

    ows_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_item),
        .o_result (w_result)
    );

    // Hold the result beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_result.status;
    assign o_write_valid        = r_result.write_valid;
    assign o_direction          = r_result.direction;
    assign o_rom_code           = r_result.rom_code;
    assign o_last_device        = r_result.last_device;
    assign o_family_discrepancy = r_result.family_discrepancy;

endmodule
